// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== src/mss_pkg.sv =====
// shared types and constants of the murmur2 shard selector
// no dependencies; used by all modules of the block
package mss_pkg;

  localparam int HASH_W = 32;
  localparam int CNT_W  = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [HASH_W-1:0] MIX_MUL     = 32'h5bd1e995;
  localparam int                MIX_SHIFT   = 24;
  localparam int                FIN_SHIFT_A = 13;
  localparam int                FIN_SHIFT_B = 15;
  localparam logic [HASH_W-1:0] SEED_RESET  = 32'd5381;
  localparam logic [HASH_W-1:0] COUNT_RESET = 32'd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HASH_SEED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SERVER_COUNT = 2'd1;

  typedef enum logic [2:0] {
    F_IDLE,
    F_K1,
    F_K2,
    F_HMIX,
    F_TAIL,
    F_FIN,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_HOLD
  } back_state_t;

  // front to queue
  typedef struct packed {
    logic              push;
    logic [HASH_W-1:0] hash;
  } q_wr_t;

  // queue to back
  typedef struct packed {
    logic              empty;
    logic [HASH_W-1:0] hash;
  } q_rd_t;

endpackage

// ===== src/murmur2_shard_select.sv =====
// top level of the murmur2 shard selector: config registers, front, queue, back
// depends on mss_pkg, mss_front, mss_queue, mss_back
//
// usage
//   input channel: push/full queue port carrying one little-endian key word,
//   its valid byte count, first/last marks and the total key length (read on
//   the first word only). an item is taken when push is high and full is low.
//   result channel: empty/pop queue port. while empty is low the oldest
//   result (hash, server index) is shown; pop with empty low takes it.
//   config channel: valid/ready write port, index 0 = hash seed, index 1 =
//   server count; ready is always high. write only while the block is idle.
// processing
//   front: k mixes and an h mix per full word, a tail mix per partial word, none per
//   empty word, finish and push on the last; one shared multiplier, one word at a time
//   back: 32 steps of the restoring divider per key, one key at a time
// last word to result
//   mix states, F_FIN, F_PUSH, queue, B_IDLE load, B_DIV, B_HOLD, result register
// reset
//   clears running hash, queue, result valid flag; config to seed 5381, count 1
// stall
//   a held result lets the divider finish the next key; the queue then
//   fills and full rises once the front has a hash it cannot hand on.
module murmur2_shard_select #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [31:0]                   in_key_word,
  input  logic [2:0]                    in_valid_bytes,
  input  logic                          in_first_word,
  input  logic [31:0]                   in_key_length,
  input  logic                          in_last_word,
  // result channel
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [31:0]                   out_hash_value,
  output logic [31:0]                   out_server_index,
  // config channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  logic [mss_pkg::HASH_W-1:0] seed_r, seed_nxt;
  logic [mss_pkg::HASH_W-1:0] count_r, count_nxt;

  mss_pkg::q_wr_t q_wr;
  mss_pkg::q_rd_t q_rd;
  logic           q_full;
  logic           q_pop;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  // register decode; unknown indexes are dropped
  always_comb begin
    seed_nxt  = seed_r;
    count_nxt = count_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        mss_pkg::REG_HASH_SEED:    seed_nxt  = cfg_data;
        mss_pkg::REG_SERVER_COUNT: count_nxt = cfg_data;
        default: seed_nxt = seed_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r  <= mss_pkg::SEED_RESET;
      count_r <= mss_pkg::COUNT_RESET;
    end else begin
      seed_r  <= seed_nxt;
      count_r <= count_nxt;
    end
  end

  // front: word mixing and finish
  mss_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .hash_seed      (seed_r),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_key_word    (in_key_word),
    .in_valid_bytes (in_valid_bytes),
    .in_first_word  (in_first_word),
    .in_key_length  (in_key_length),
    .in_last_word   (in_last_word),
    .wr             (q_wr),
    .q_full         (q_full)
  );

  // finished hashes waiting for the divider
  mss_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .full  (q_full),
    .pop   (q_pop),
    .rd    (q_rd)
  );

  // back: modulo and result register
  mss_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .server_count     (count_r),
    .rd               (q_rd),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_hash_value   (out_hash_value),
    .out_server_index (out_server_index)
  );

endmodule

// ===== src/mss_queue.sv =====
// short queue of finished hashes between front and back
// depends on mss_pkg
module mss_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mss_pkg::q_wr_t wr,
  output logic          full,
  input  logic          pop,
  output mss_pkg::q_rd_t rd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [mss_pkg::HASH_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign rd.empty = (count_r == '0);
  assign rd.hash  = mem[rd_ptr_r];
  assign do_wr    = wr.push && !full;
  assign do_rd    = pop && !rd.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr.hash;
    end
  end

endmodule

// ===== src/mss_front.sv =====
// front end: accepts key words, mixes them and finishes the hash
// depends on mss_pkg; one shared 32-bit multiplier
module mss_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [mss_pkg::HASH_W-1:0] hash_seed,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [31:0]                in_key_word,
  input  logic [2:0]                 in_valid_bytes,
  input  logic                       in_first_word,
  input  logic [31:0]                in_key_length,
  input  logic                       in_last_word,
  output mss_pkg::q_wr_t             wr,
  input  logic                       q_full
);

  mss_pkg::front_state_t state_r, state_nxt;

  logic [31:0] h_r, h_nxt;
  logic [31:0] k_r, k_nxt;
  logic [31:0] fin_r, fin_nxt;
  logic [31:0] word_r;
  logic [1:0]  nb_r;
  logic        last_r;
  logic        accept;
  logic [31:0] mul_a, mul_p, tail_mask;

  assign accept = in_push && (state_r == mss_pkg::F_IDLE);
  assign mul_p  = mul_a * mss_pkg::MIX_MUL;

  always_comb begin
    case (nb_r)
      2'd1:    tail_mask = 32'h0000_00ff;
      2'd2:    tail_mask = 32'h0000_ffff;
      default: tail_mask = 32'h00ff_ffff;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mss_pkg::F_IDLE: begin
        if (accept) begin
          if (in_valid_bytes[2]) begin
            state_nxt = mss_pkg::F_K1;
          end else if (in_valid_bytes != 3'd0) begin
            state_nxt = mss_pkg::F_TAIL;
          end else if (in_last_word) begin
            state_nxt = mss_pkg::F_FIN;
          end
        end
      end
      mss_pkg::F_K1:   state_nxt = mss_pkg::F_K2;
      mss_pkg::F_K2:   state_nxt = mss_pkg::F_HMIX;
      mss_pkg::F_HMIX,
      mss_pkg::F_TAIL: state_nxt = last_r ? mss_pkg::F_FIN : mss_pkg::F_IDLE;
      mss_pkg::F_FIN:  state_nxt = mss_pkg::F_PUSH;
      mss_pkg::F_PUSH: begin
        if (!q_full) begin
          state_nxt = mss_pkg::F_IDLE;
        end
      end
      default: state_nxt = mss_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    h_nxt   = h_r;
    k_nxt   = k_r;
    fin_nxt = fin_r;
    mul_a   = '0;
    in_full = 1'b1;
    wr.push = 1'b0;
    wr.hash = fin_r ^ (fin_r >> mss_pkg::FIN_SHIFT_B);
    unique case (state_r)
      mss_pkg::F_IDLE: begin
        in_full = 1'b0;
        if (accept && in_first_word) begin
          h_nxt = hash_seed ^ in_key_length;
        end
      end
      mss_pkg::F_K1: begin
        mul_a = word_r;
        k_nxt = mul_p;
      end
      mss_pkg::F_K2: begin
        mul_a = k_r ^ (k_r >> mss_pkg::MIX_SHIFT);
        k_nxt = mul_p;
      end
      mss_pkg::F_HMIX: begin
        mul_a = h_r;
        h_nxt = mul_p ^ k_r;
      end
      mss_pkg::F_TAIL: begin
        mul_a = h_r ^ (word_r & tail_mask);
        h_nxt = mul_p;
      end
      mss_pkg::F_FIN: begin
        // running hash stays unfinished for a following key word
        mul_a   = h_r ^ (h_r >> mss_pkg::FIN_SHIFT_A);
        fin_nxt = mul_p;
      end
      mss_pkg::F_PUSH: begin
        wr.push = !q_full;
      end
      default: begin
        in_full = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mss_pkg::F_IDLE;
      h_r     <= '0;
    end else begin
      state_r <= state_nxt;
      h_r     <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    fin_r <= fin_nxt;
    if (accept) begin
      word_r <= in_key_word;
      nb_r   <= in_valid_bytes[1:0];
      last_r <= in_last_word;
    end
  end

endmodule

// ===== src/mss_back.sv =====
// back end: reduces a finished hash modulo the server count
// depends on mss_pkg; restoring divider, one quotient bit per cycle
module mss_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [mss_pkg::HASH_W-1:0] server_count,
  input  mss_pkg::q_rd_t             rd,
  output logic                       q_pop,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [31:0]                out_hash_value,
  output logic [31:0]                out_server_index
);

  localparam int W = mss_pkg::HASH_W;

  mss_pkg::back_state_t state_r, state_nxt;

  logic [W-1:0]   dvd_r, hash_r, rem_r;
  logic [mss_pkg::CNT_W-1:0] cnt_r;
  logic           out_valid_r, out_valid_nxt;
  logic [W-1:0]   out_hash_r, out_idx_r;
  logic           load, step, out_load, out_take;
  logic [W:0]     rem_sh;
  logic [W+1:0]   diff;
  logic [W-1:0]   rem_step;

  assign rem_sh   = {rem_r, dvd_r[W-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, server_count};
  assign rem_step = diff[W+1] ? rem_sh[W-1:0] : diff[W-1:0];
  assign out_take = out_pop && out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mss_pkg::B_IDLE: begin
        if (!rd.empty) begin
          state_nxt = mss_pkg::B_DIV;
        end
      end
      mss_pkg::B_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = mss_pkg::B_HOLD;
        end
      end
      mss_pkg::B_HOLD: begin
        if (!out_valid_r || out_pop) begin
          state_nxt = mss_pkg::B_IDLE;
        end
      end
      default: state_nxt = mss_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    load     = 1'b0;
    step     = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      mss_pkg::B_IDLE: load     = !rd.empty;
      mss_pkg::B_DIV:  step     = 1'b1;
      mss_pkg::B_HOLD: out_load = !out_valid_r || out_pop;
      default: load = 1'b0;
    endcase
  end

  assign q_pop = load;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mss_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dvd_r  <= rd.hash;
      hash_r <= rd.hash;
      rem_r  <= '0;
      cnt_r  <= mss_pkg::CNT_W'(W - 1);
    end else if (step) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_step;
      cnt_r <= cnt_r - 1'b1;
    end
    if (out_load) begin
      out_hash_r <= hash_r;
      out_idx_r  <= (server_count == '0) ? '0 : rem_r;
    end
  end

  assign out_empty        = !out_valid_r;
  assign out_hash_value   = out_hash_r;
  assign out_server_index = out_idx_r;

endmodule

// ===== src/mss_checker.sv =====
// port-level checks of the murmur2 shard selector, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module mss_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_push,
  input logic        in_full,
  input logic [2:0]  in_valid_bytes,
  input logic        out_empty,
  input logic        out_pop,
  input logic [31:0] out_hash_value,
  input logic [31:0] out_server_index
);

  // a waiting result holds until taken
  `ASSERT_NEXT(a_out_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_hash_value) && $stable(out_server_index))

  // a remainder never exceeds its dividend
  `ASSERT_IMPL(a_idx_range, clk, rst_n, !out_empty, out_server_index <= out_hash_value)

  // a taken full word sets full for its first mixing step
  `ASSERT_NEXT(a_full_busy, clk, rst_n, in_push && !in_full && in_valid_bytes[2], in_full)

endmodule

bind murmur2_shard_select mss_checker u_chk (.*);

// ===== tb/tb_murmur2_shard_select.sv =====
// testbench for the murmur2 shard selector: directed table, then random keys
// depends on mss_pkg and murmur2_shard_select; self-checking against its own predictor
module tb_murmur2_shard_select;

  // one key word request as it goes onto the input port
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        is_first;
    logic [31:0] klen;
    logic        is_last;
  } key_item_t;

  // one finished key: raw hash and selected shard
  typedef struct packed {
    logic [31:0] hash;
    logic [31:0] server_idx;
  } shard_result_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  // directed row; a config row carries the seed in word and the count in klen
  typedef struct {
    row_kind_t     kind;
    key_item_t     item;
    bit            pinned;
    shard_result_t want;
  } dir_row_t;

  localparam int NUM_ROWS   = 22;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 112;
  // time for a word in the front and the divider to settle, with margin
  localparam int SETTLE_CYCLES = 80;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_push = 1'b0;
  logic                          in_full;
  logic [31:0]                   in_key_word = '0;
  logic [2:0]                    in_valid_bytes = '0;
  logic                          in_first_word = 1'b0;
  logic [31:0]                   in_key_length = '0;
  logic                          in_last_word = 1'b0;
  logic                          out_empty;
  logic                          out_pop = 1'b0;
  logic [31:0]                   out_hash_value;
  logic [31:0]                   out_server_index;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [mss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]                   cfg_data = '0;

  // predictor state and its copy of the config registers
  logic [31:0]   run_hash = '0;
  logic [31:0]   cur_seed = mss_pkg::SEED_RESET;
  logic [31:0]   cur_count = mss_pkg::COUNT_RESET;
  shard_result_t pending_shards[$];

  int mismatch_count = 0;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;

  murmur2_shard_select u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_key_word      (in_key_word),
    .in_valid_bytes   (in_valid_bytes),
    .in_first_word    (in_first_word),
    .in_key_length    (in_key_length),
    .in_last_word     (in_last_word),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_hash_value   (out_hash_value),
    .out_server_index (out_server_index),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop well past the slowest legal run
  initial begin
    #1600000;
    $display("CHECK FAILED");
    $finish;
  end

  // directed table: reset state, field extremes, every special case
  dir_row_t directed_rows [NUM_ROWS] = '{
    // no first word right after reset: hash starts from zero
    '{ROW_ITEM, '{32'h0000_0000, 3'd0, 1'b0, 32'd0, 1'b1}, 1'b1, '{32'h0, 32'h0}},
    // empty key whose length cancels the reset seed; all word bytes ignored
    '{ROW_ITEM, '{32'hFFFF_FFFF, 3'd0, 1'b1, 32'd5381, 1'b1}, 1'b1, '{32'h0, 32'h0}},
    // multi-word key with partial words in the middle
    '{ROW_ITEM, '{32'hFFFF_FFFF, 3'd4, 1'b1, 32'hFFFF_FFFF, 1'b0}, 1'b0, '{32'h0, 32'h0}},
    '{ROW_ITEM, '{32'h0000_0000, 3'd4, 1'b0, 32'd0, 1'b0}, 1'b0, '{32'h0, 32'h0}},
    '{ROW_ITEM, '{32'hFFFF_FFFF, 3'd1, 1'b0, 32'd0, 1'b0}, 1'b0, '{32'h0, 32'h0}},
    '{ROW_ITEM, '{32'h1234_5678, 3'd2, 1'b0, 32'd0, 1'b0}, 1'b0, '{32'h0, 32'h0}},
    '{ROW_ITEM, '{32'h9ABC_DEF0, 3'd3, 1'b0, 32'd0, 1'b1}, 1'b0, '{32'h0, 32'h0}},
    // carries on from the unfinished hash after a last word
    '{ROW_ITEM, '{32'h0000_0000, 3'd4, 1'b0, 32'd0, 1'b1}, 1'b0, '{32'h0, 32'h0}},
    // byte counts above four act as full words
    '{ROW_ITEM, '{32'hA5A5_A5A5, 3'd5, 1'b1, 32'd4, 1'b1}, 1'b0, '{32'h0, 32'h0}},
    '{ROW_ITEM, '{32'h5A5A_5A5A, 3'd6, 1'b1, 32'd8, 1'b0}, 1'b0, '{32'h0, 32'h0}},
    '{ROW_ITEM, '{32'h3C3C_3C3C, 3'd7, 1'b0, 32'd8, 1'b1}, 1'b0, '{32'h0, 32'h0}},
    // three-byte key in one word
    '{ROW_ITEM, '{32'h0063_6261, 3'd3, 1'b1, 32'd3, 1'b1}, 1'b0, '{32'h0, 32'h0}},
    // key length not matching the bytes sent
    '{ROW_ITEM, '{32'h0000_0000, 3'd1, 1'b1, 32'd100, 1'b1}, 1'b0, '{32'h0, 32'h0}},
    // zero seed, zero server count
    '{ROW_CFG,  '{32'h0000_0000, 3'd0, 1'b0, 32'h0000_0000, 1'b0}, 1'b0, '{32'h0, 32'h0}},
    '{ROW_ITEM, '{32'h0000_0000, 3'd0, 1'b1, 32'd0, 1'b1}, 1'b1, '{32'h0, 32'h0}},
    '{ROW_ITEM, '{32'hFFFF_FFFF, 3'd4, 1'b1, 32'd4, 1'b1}, 1'b0, '{32'h0, 32'h0}},
    // all-ones seed and server count
    '{ROW_CFG,  '{32'hFFFF_FFFF, 3'd0, 1'b0, 32'hFFFF_FFFF, 1'b0}, 1'b0, '{32'h0, 32'h0}},
    '{ROW_ITEM, '{32'h0000_0000, 3'd0, 1'b1, 32'hFFFF_FFFF, 1'b1}, 1'b1, '{32'h0, 32'h0}},
    '{ROW_ITEM, '{32'h8000_0000, 3'd4, 1'b1, 32'd4, 1'b1}, 1'b0, '{32'h0, 32'h0}},
    // small odd server count
    '{ROW_CFG,  '{32'h1234_ABCD, 3'd0, 1'b0, 32'd7, 1'b0}, 1'b0, '{32'h0, 32'h0}},
    '{ROW_ITEM, '{32'hDEAD_BEEF, 3'd4, 1'b1, 32'd7, 1'b0}, 1'b0, '{32'h0, 32'h0}},
    '{ROW_ITEM, '{32'h00C0_FFEE, 3'd3, 1'b0, 32'd7, 1'b1}, 1'b0, '{32'h0, 32'h0}}
  };

  // full four-byte block mix
  function automatic logic [31:0] mix_block(input logic [31:0] h, input logic [31:0] k);
    logic [31:0] m;
    m = k * mss_pkg::MIX_MUL;
    m = m ^ (m >> mss_pkg::MIX_SHIFT);
    m = m * mss_pkg::MIX_MUL;
    h = h * mss_pkg::MIX_MUL;
    return h ^ m;
  endfunction

  // tail mix of one to three bytes
  function automatic logic [31:0] mix_tail_bytes(input logic [31:0] h, input logic [31:0] k,
                                                 input logic [2:0] nbytes);
    logic [31:0] keep;
    keep = (nbytes == 3'd1) ? 32'h0000_00FF :
           (nbytes == 3'd2) ? 32'h0000_FFFF : 32'h00FF_FFFF;
    h = h ^ (k & keep);
    return h * mss_pkg::MIX_MUL;
  endfunction

  function automatic logic [31:0] avalanche(input logic [31:0] h);
    h = h ^ (h >> mss_pkg::FIN_SHIFT_A);
    h = h * mss_pkg::MIX_MUL;
    return h ^ (h >> mss_pkg::FIN_SHIFT_B);
  endfunction

  // advance the predicted hash by one accepted request, queue a result on the last word
  task automatic predict_shard(input key_item_t it, input bit pinned, input shard_result_t want);
    shard_result_t res;
    if (it.is_first) begin
      run_hash = cur_seed ^ it.klen;
    end
    if (it.nbytes >= 3'd4) begin
      run_hash = mix_block(run_hash, it.word);
    end else if (it.nbytes != 3'd0) begin
      run_hash = mix_tail_bytes(run_hash, it.word, it.nbytes);
    end
    if (it.is_last) begin
      res.hash = avalanche(run_hash);
      res.server_idx = (cur_count != 32'd0) ? res.hash % cur_count : 32'd0;
      pending_shards.push_back(pinned ? want : res);
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // random sender gaps, then hold the request until the front takes it
  task automatic send_word(input key_item_t it, input bit pinned, input shard_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push        <= 1'b1;
    in_key_word    <= it.word;
    in_valid_bytes <= it.nbytes;
    in_first_word  <= it.is_first;
    in_key_length  <= it.klen;
    in_last_word   <= it.is_last;
    do @(posedge clk); while (in_full);
    predict_shard(it, pinned, want);
  endtask

  // stop sending, wait for every queued result, then let a word still in the front settle
  task automatic drain_block();
    in_push <= 1'b0;
    while (pending_shards.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called on an idle block; valid is raised once and dropped after both writes
  task automatic write_reg(input logic [mss_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == mss_pkg::REG_HASH_SEED) begin
      cur_seed = value;
    end else begin
      cur_count = value;
    end
  endtask

  task automatic set_config(input logic [31:0] seed, input logic [31:0] count);
    drain_block();
    write_reg(mss_pkg::REG_HASH_SEED, seed);
    write_reg(mss_pkg::REG_SERVER_COUNT, count);
    cfg_valid <= 1'b0;
  endtask

  // one random key: mostly well-formed word streams, some noise and broken keys;
  // returns the number of requests sent
  task automatic send_random_key(output int sent);
    key_item_t it;
    int key_len;
    int nwords;
    int pick;
    sent = 0;
    pick = $urandom_range(99);
    if (pick < 12) begin
      // noise request: any field combination, byte counts up to seven
      it.word     = $urandom;
      it.nbytes   = 3'($urandom_range(7));
      it.is_first = 1'($urandom_range(1));
      it.klen     = $urandom;
      it.is_last  = 1'($urandom_range(1));
      send_word(it, 1'b0, '0);
      sent = 1;
    end else begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        key_len = 0;
      end else if (pick < 85) begin
        key_len = $urandom_range(1, 16);
      end else begin
        key_len = $urandom_range(17, 64);
      end
      nwords = (key_len == 0) ? 1 : (key_len + 3) / 4;
      for (int w = 0; w < nwords; w++) begin
        it.word     = $urandom;
        it.nbytes   = (w < nwords - 1 || key_len % 4 == 0) ? 3'd4 : 3'(key_len % 4);
        if (key_len == 0) it.nbytes = 3'd0;
        // a few keys lose their first mark or carry a wrong length
        it.is_first = (w == 0) && ($urandom_range(99) >= 4);
        it.klen     = ($urandom_range(99) < 10) ? 32'($urandom) : 32'(key_len);
        it.is_last  = (w == nwords - 1);
        send_word(it, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // result side: random stalls on pop, compare the oldest expected shard
  always @(posedge clk) begin
    shard_result_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_shards.size() == 0) begin
        flag_mismatch("result with no request pending, hash", out_hash_value, 32'h0);
      end else begin
        want = pending_shards.pop_front();
        if (out_hash_value !== want.hash) begin
          flag_mismatch("hash_value", out_hash_value, want.hash);
        end
        if (out_server_index !== want.server_idx) begin
          flag_mismatch("server_index", out_server_index, want.server_idx);
        end
      end
    end
    out_pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // main sequence
  initial begin
    int phase_sent;
    int n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed table with no idling on either side
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        set_config(directed_rows[r].item.word, directed_rows[r].item.klen);
      end else begin
        send_word(directed_rows[r].item, directed_rows[r].pinned, directed_rows[r].want);
      end
    end

    // random phases, each with its own register setting and idling mix
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: set_config($urandom, $urandom_range(2, 16));
        1: set_config(32'h0000_0000, 32'd1);
        2: set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        3: set_config($urandom, $urandom);
        4: set_config(mss_pkg::SEED_RESET, 32'd3);
        5: set_config($urandom, $urandom_range(1, 1000));
        6: set_config(32'hFFFF_FFFF, 32'h8000_0000);
        default: set_config($urandom, $urandom | 32'd1);
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 57; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 57; end
        default: begin send_idle_pct = 23; pop_stall_pct = 23; end
      endcase
      phase_sent = 0;
      while (phase_sent < PHASE_ITEMS) begin
        send_random_key(n);
        phase_sent += n;
      end
    end

    // wait out every result; the hard stop catches anything left pending
    drain_block();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/mss_pkg.sv
src/mss_queue.sv
src/mss_front.sv
src/mss_back.sv
src/murmur2_shard_select.sv
src/mss_checker.sv
tb/tb_murmur2_shard_select.sv
